@@ sv/sct_pkg.sv @@
// Package with shared widths, defaults and the pipeline item type of the sine/cosine block.
`timescale 1ns / 1ps
package sct_pkg;
   localparam int TERMS_DEF     = 10;
   localparam int FRAC_BITS_DEF = 28;
   localparam int ANGLE_W       = 32;
   localparam int MAG_W         = 57;
   localparam int ACC_W         = 64;
   localparam int WORD_W        = 64;
   localparam int DIV_W         = 6;
   localparam int DIV_BITS      = 8;
   localparam int DIV_STAGES    = WORD_W / DIV_BITS;

   typedef struct packed {
      logic               vld;
      logic               cos;
      logic               xneg;
      logic [ANGLE_W-1:0] ux;
      logic [ACC_W-1:0]   acc;
      logic               cap;
      logic [MAG_W-1:0]   mag;
   } item_type;
endpackage

@@ sv/sct_step.sv @@
// One series step: magnitude times |x| with rounding and capping, then a pipelined rounded divide.
`timescale 1ns / 1ps
module sct_step import sct_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int D_SIN     = 2,
   parameter int D_COS     = 1
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  item_type in_item,
   output item_type out_item
);
   localparam int X_W    = DIV_W + DIV_BITS;
   localparam int RCP_SH = X_W + DIV_W;
   localparam int RCP_W  = RCP_SH + 1;

   localparam logic [DIV_W-1:0]  DS     = DIV_W'(D_SIN);
   localparam logic [DIV_W-1:0]  DC     = DIV_W'(D_COS);
   localparam logic [RCP_W-1:0]  RS     = RCP_W'(((1 << RCP_SH) + D_SIN - 1) / D_SIN);
   localparam logic [RCP_W-1:0]  RC     = RCP_W'(((1 << RCP_SH) + D_COS - 1) / D_COS);
   localparam logic [MAG_W-1:0]  HI_LIM = MAG_W'(1) << (24 + FRAC_BITS);
   localparam logic [WORD_W-1:0] HALF   = WORD_W'(1) << (FRAC_BITS - 1);
   localparam logic [WORD_W-1:0] TCAP   = WORD_W'(1) << 56;

   item_type          mul_item_ff;
   logic [MAG_W-1:0]  hi_ff, hi_in;
   logic [WORD_W-1:0] lo_ff, lo_in;

   item_type          item_ff [0:DIV_STAGES];
   logic [WORD_W-1:0] word_ff [0:DIV_STAGES];
   logic [DIV_W-1:0]  rem_ff  [0:DIV_STAGES];
   logic [DIV_W-1:0]  dv_ff   [0:DIV_STAGES];

   item_type          stage_in;
   logic [DIV_W-1:0]  dv_in;
   logic [WORD_W-1:0] r_full;
   logic              rcap;
   logic [MAG_W-1:0]  mag_c;
   logic [WORD_W-1:0] num_in;

   assign hi_in = {32'd0, in_item.mag[MAG_W-1:32]} * {25'd0, in_item.ux};
   assign lo_in = {32'd0, in_item.mag[31:0]} * {32'd0, in_item.ux};

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_item_ff <= '0;
      end else if (en) begin
         mul_item_ff <= in_item;
      end
      if (en) begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
   end

   always_comb begin
      dv_in  = mul_item_ff.cos ? DC : DS;
      r_full = ({7'd0, hi_ff} << (32 - FRAC_BITS)) + ((lo_ff + HALF) >> FRAC_BITS);
      rcap   = (hi_ff > HI_LIM) || (r_full > TCAP);
      mag_c  = rcap ? TCAP[MAG_W-1:0] : r_full[MAG_W-1:0];
      num_in = {7'd0, mag_c} + {{(WORD_W-DIV_W){1'b0}}, (dv_in >> 1)};
      stage_in     = mul_item_ff;
      stage_in.cap = mul_item_ff.cap | rcap;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff[0] <= '0;
      end else if (en) begin
         item_ff[0] <= stage_in;
      end
      if (en) begin
         word_ff[0] <= num_in;
         rem_ff[0]  <= '0;
         dv_ff[0]   <= dv_in;
      end
   end

   // Each stage takes one quotient digit: the partial remainder and the next digit of the
   // dividend are divided by a reciprocal multiply, which is exact for this operand range.
   for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_div
      logic [WORD_W-1:0]      word_in;
      logic [DIV_W-1:0]       rem_in;
      logic [X_W-1:0]         x;
      logic [RCP_W-1:0]       rcp;
      logic [X_W+RCP_W-1:0]   prod;
      logic [DIV_BITS-1:0]    q;
      logic [X_W-1:0]         qd;

      always_comb begin
         x       = {rem_ff[s-1], word_ff[s-1][WORD_W-1 -: DIV_BITS]};
         rcp     = item_ff[s-1].cos ? RC : RS;
         prod    = {{RCP_W{1'b0}}, x} * {{X_W{1'b0}}, rcp};
         q       = prod[RCP_SH +: DIV_BITS];
         qd      = {{DIV_W{1'b0}}, q} * {{DIV_BITS{1'b0}}, dv_ff[s-1]};
         rem_in  = DIV_W'(x - qd);
         word_in = {word_ff[s-1][WORD_W-DIV_BITS-1:0], q};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            item_ff[s] <= '0;
         end else if (en) begin
            item_ff[s] <= item_ff[s-1];
         end
         if (en) begin
            word_ff[s] <= word_in;
            rem_ff[s]  <= rem_in;
            dv_ff[s]   <= dv_ff[s-1];
         end
      end
   end

   always_comb begin
      out_item     = item_ff[DIV_STAGES];
      out_item.mag = word_ff[DIV_STAGES][MAG_W-1:0];
   end
endmodule

@@ sv/sine_cosine_taylor.sv @@
// Top level of the pipelined fixed-point sine/cosine Maclaurin series block.
//
// Channel  Direction  Ports
// req      in         req_valid, req_ready, req_mode, req_angle
// rsp      out        rsp_valid, rsp_ready, rsp_value, rsp_saturated
//
// One item is accepted every cycle while the pipeline is not frozen (req_ready high); the
// digit stages of the dividers make up most of the pipeline depth.
// Reset clears all valid bits and the output valid.
// The whole pipeline freezes when its last stage holds an item and the output register
// is full and not being taken; empty slots do not move during that time either.
`timescale 1ns / 1ps
module sine_cosine_taylor import sct_pkg::*; #(
   parameter int TERMS     = TERMS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_mode,
   input  logic signed [ANGLE_W-1:0] req_angle,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [ANGLE_W-1:0] rsp_value,
   output logic                      rsp_saturated
);
   localparam logic [ACC_W-1:0] ONE = ACC_W'(1) << FRAC_BITS;

   item_type acc_ff [0:TERMS-1];
   item_type entry_in;
   item_type last_item;
   logic     en;

   logic                      rsp_valid_ff;
   logic signed [ANGLE_W-1:0] rsp_value_ff, value_in;
   logic                      rsp_saturated_ff, sat_in;
   logic                      fits;

   assign last_item = acc_ff[TERMS-1];
   assign en        = !(last_item.vld && rsp_valid_ff && !rsp_ready);
   assign req_ready = en;

   always_comb begin
      entry_in      = '0;
      entry_in.vld  = req_valid;
      entry_in.cos  = req_mode;
      entry_in.xneg = req_angle[ANGLE_W-1];
      entry_in.ux   = req_angle[ANGLE_W-1] ? (~req_angle + 1'b1) : req_angle;
      entry_in.mag  = req_mode ? ONE[MAG_W-1:0] : {25'd0, entry_in.ux};
      entry_in.acc  = (!req_mode && req_angle[ANGLE_W-1]) ?
                      (ACC_W'(0) - {7'd0, entry_in.mag}) : {7'd0, entry_in.mag};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff[0] <= '0;
      end else if (en) begin
         acc_ff[0] <= entry_in;
      end
   end

   for (genvar k = 0; k < TERMS - 1; k++) begin : g_term
      item_type a_out, b_out, sum_in;
      logic     neg;

      sct_step #(
         .FRAC_BITS (FRAC_BITS),
         .D_SIN     (2 * k + 2),
         .D_COS     (2 * k + 1)
      ) u_step_a (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_item  (acc_ff[k]),
         .out_item (a_out)
      );

      sct_step #(
         .FRAC_BITS (FRAC_BITS),
         .D_SIN     (2 * k + 3),
         .D_COS     (2 * k + 2)
      ) u_step_b (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_item  (a_out),
         .out_item (b_out)
      );

      always_comb begin
         neg        = (((k + 1) % 2) == 1) ^ (!b_out.cos && b_out.xneg);
         sum_in     = b_out;
         sum_in.acc = neg ? (b_out.acc - {7'd0, b_out.mag}) : (b_out.acc + {7'd0, b_out.mag});
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            acc_ff[k+1] <= '0;
         end else if (en) begin
            acc_ff[k+1] <= sum_in;
         end
      end
   end

   always_comb begin
      fits = (last_item.acc[ACC_W-1:ANGLE_W-1] == '0) ||
             (last_item.acc[ACC_W-1:ANGLE_W-1] == '1);
      if (last_item.cap || !fits) begin
         sat_in   = 1'b1;
         value_in = last_item.acc[ACC_W-1] ? {1'b1, {(ANGLE_W-1){1'b0}}}
                                           : {1'b0, {(ANGLE_W-1){1'b1}}};
      end else begin
         sat_in   = 1'b0;
         value_in = last_item.acc[ANGLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en && last_item.vld) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (en && last_item.vld) begin
         rsp_value_ff     <= value_in;
         rsp_saturated_ff <= sat_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_saturated = rsp_saturated_ff;
endmodule
